>>> src/shape_pair_collision_test_defines.svh
// assertion macros shared by the checker files
`ifndef SHAPE_PAIR_COLLISION_TEST_DEFINES_SVH
`define SHAPE_PAIR_COLLISION_TEST_DEFINES_SVH

// property checked only while out of reset
`define SCPT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shape pair collision test: assertion failed");

// property checked on every edge, reset included
`define SCPT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("shape pair collision test: assertion failed");

`endif

>>> src/scpt_pkg.sv
package scpt_pkg;

    localparam int COORD_BITS_DEF = 24;

    typedef logic [1:0] func_t;

    localparam func_t FUNC_RECT_RECT = 2'd0;
    localparam func_t FUNC_CIRC_CIRC = 2'd1;
    localparam func_t FUNC_CIRC_RECT = 2'd2;

    // per-item control that rides along the pipeline
    typedef struct packed {
        func_t func;
        logic  rect_hit;
        logic  early_reject;
        logic  early_accept;
    } pair_flags_t;

endpackage

>>> src/scpt_prep.sv
module scpt_prep
    import scpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  load,
    input  func_t                 func,
    input  logic [COORD_BITS-1:0] ax,
    input  logic [COORD_BITS-1:0] ay,
    input  logic [COORD_BITS-2:0] aw,
    input  logic [COORD_BITS-2:0] ah,
    input  logic [COORD_BITS-1:0] bx,
    input  logic [COORD_BITS-1:0] by,
    input  logic [COORD_BITS-2:0] bw,
    input  logic [COORD_BITS-2:0] bh,
    output pair_flags_t           flags_reg,
    output logic [COORD_BITS:0]   dx_reg,
    output logic [COORD_BITS:0]   dy_reg,
    output logic [COORD_BITS-1:0] rad_reg,
    output logic [COORD_BITS-2:0] w_reg,
    output logic [COORD_BITS-2:0] h_reg,
    output logic [COORD_BITS:0]   wr_reg,
    output logic [COORD_BITS:0]   hr_reg
);

    localparam int CW = COORD_BITS;

    logic signed [CW:0] ax_e, ay_e, bx_e, by_e;
    logic signed [CW:0] aw_e, ah_e, bw_e, bh_e;
    logic               rect_hit;
    pair_flags_t        flags_next;
    logic [CW-1:0]      rad_next;

    assign ax_e = $signed({ax[CW-1], ax});
    assign ay_e = $signed({ay[CW-1], ay});
    assign bx_e = $signed({bx[CW-1], bx});
    assign by_e = $signed({by[CW-1], by});
    assign aw_e = $signed({2'b00, aw});
    assign ah_e = $signed({2'b00, ah});
    assign bw_e = $signed({2'b00, bw});
    assign bh_e = $signed({2'b00, bh});

    // strict box overlap, positions are minimum corners
    assign rect_hit = (ax_e < bx_e + bw_e) && (ax_e + aw_e > bx_e)
                   && (ay_e < by_e + bh_e) && (ay_e + ah_e > by_e);

    // radius sum for two circles, doubled radius against a box
    assign rad_next = (func == FUNC_CIRC_CIRC) ? ({1'b0, aw} + {1'b0, bw}) : {aw, 1'b0};

    always_comb begin
        flags_next              = '0;
        flags_next.func         = func;
        flags_next.rect_hit     = rect_hit;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg <= flags_next;
            dx_reg    <= ax_e - bx_e;
            dy_reg    <= ay_e - by_e;
            rad_reg   <= rad_next;
            w_reg     <= bw;
            h_reg     <= bh;
            wr_reg    <= {2'b00, bw} + {1'b0, aw, 1'b0};
            hr_reg    <= {2'b00, bh} + {1'b0, aw, 1'b0};
        end
    end

endmodule

>>> src/scpt_reduce.sv
module scpt_reduce
    import scpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  load,
    input  pair_flags_t           flags_in,
    input  logic [COORD_BITS:0]   dx,
    input  logic [COORD_BITS:0]   dy,
    input  logic [COORD_BITS-1:0] rad,
    input  logic [COORD_BITS-2:0] w,
    input  logic [COORD_BITS-2:0] h,
    input  logic [COORD_BITS:0]   wr,
    input  logic [COORD_BITS:0]   hr,
    output pair_flags_t           flags_reg,
    output logic [COORD_BITS-1:0] opx_reg,
    output logic [COORD_BITS-1:0] opy_reg,
    output logic [COORD_BITS-1:0] rad_reg
);

    localparam int CW = COORD_BITS;

    logic [CW:0]   ndx, ndy;
    logic [CW-1:0] adx, ady;
    logic [CW:0]   dx2, dy2;
    logic [CW:0]   ex, ey;
    pair_flags_t   flags_next;

    // absolute distance always fits in CW bits
    assign ndx = -dx;
    assign ndy = -dy;
    assign adx = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
    assign ady = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
    assign dx2 = {adx, 1'b0};
    assign dy2 = {ady, 1'b0};

    // corner excess, at most the doubled radius whenever it is used
    assign ex = dx2 - {2'b00, w};
    assign ey = dy2 - {2'b00, h};

    always_comb begin
        flags_next              = flags_in;
        flags_next.early_reject = (dx2 > wr) || (dy2 > hr);
        flags_next.early_accept = (dx2 <= {2'b00, w}) || (dy2 <= {2'b00, h});
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg <= flags_next;
            opx_reg   <= (flags_in.func == FUNC_CIRC_RECT) ? ex[CW-1:0] : adx;
            opy_reg   <= (flags_in.func == FUNC_CIRC_RECT) ? ey[CW-1:0] : ady;
            rad_reg   <= rad;
        end
    end

endmodule

>>> src/scpt_square.sv
module scpt_square
    import scpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    load,
    input  pair_flags_t             flags_in,
    input  logic [COORD_BITS-1:0]   opx,
    input  logic [COORD_BITS-1:0]   opy,
    input  logic [COORD_BITS-1:0]   rad,
    output pair_flags_t             flags_reg,
    output logic [2*COORD_BITS-1:0] sqx_reg,
    output logic [2*COORD_BITS-1:0] sqy_reg,
    output logic [2*COORD_BITS-1:0] sqr_reg
);

    localparam int PW = 2 * COORD_BITS;

    logic [PW-1:0] opx_w, opy_w, rad_w;

    assign opx_w = {{COORD_BITS{1'b0}}, opx};
    assign opy_w = {{COORD_BITS{1'b0}}, opy};
    assign rad_w = {{COORD_BITS{1'b0}}, rad};

    // three squarers in parallel
    always_ff @(posedge aclk) begin
        if (load) begin
            flags_reg <= flags_in;
            sqx_reg   <= opx_w * opx_w;
            sqy_reg   <= opy_w * opy_w;
            sqr_reg   <= rad_w * rad_w;
        end
    end

endmodule

>>> src/scpt_decide.sv
module scpt_decide
    import scpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    load,
    input  pair_flags_t             flags_in,
    input  logic [2*COORD_BITS-1:0] sqx,
    input  logic [2*COORD_BITS-1:0] sqy,
    input  logic [2*COORD_BITS-1:0] sqr,
    output logic                    colliding_reg
);

    localparam int PW = 2 * COORD_BITS;

    logic [PW:0] dist_sq;
    logic [PW:0] lim;
    logic        colliding_next;

    assign dist_sq = {1'b0, sqx} + {1'b0, sqy};
    assign lim     = {1'b0, sqr};

    always_comb begin
        case (flags_in.func)
            FUNC_RECT_RECT: colliding_next = flags_in.rect_hit;
            FUNC_CIRC_CIRC: colliding_next = dist_sq < lim;
            FUNC_CIRC_RECT: colliding_next = !flags_in.early_reject
                                          && (flags_in.early_accept || dist_sq <= lim);
            default:        colliding_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            colliding_reg <= colliding_next;
        end
    end

endmodule

>>> src/shape_pair_collision_test.sv
// overlap test for one pair of 2-D shapes per transfer
//
// input channel s_*: pair kind in s_func (rect-rect, circle-circle,
//   circle against rect) and two shapes as signed Q15.8 positions with
//   unsigned Q15.8 extents; the unused pair kind always answers 0
// result channel m_*: one bit m_colliding per input transfer, in order
//
// path: each pair passes the difference stage, abs/early test stage, squaring
//   stage and compare stage in that order, each registered, before m_valid rises
// throughput: one pair per cycle unless m_ready holds the output stage; the
//   three squarers of the third stage are the widest path and each holds one product per cycle
// reset: aresetn low clears every stage valid bit, so m_valid drops and
//   in-flight pairs are dropped; no other register is reset
// stall: when m_ready is low the output stage holds its result; upstream
//   stages keep moving until they bunch up behind it, and only then does
//   s_ready fall, so bubbles are squeezed out and nothing is lost
module shape_pair_collision_test
    import scpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_func,
    input  logic [COORD_BITS-1:0] s_first_x,
    input  logic [COORD_BITS-1:0] s_first_y,
    input  logic [COORD_BITS-2:0] s_first_extent_x,
    input  logic [COORD_BITS-2:0] s_first_extent_y,
    input  logic [COORD_BITS-1:0] s_second_x,
    input  logic [COORD_BITS-1:0] s_second_y,
    input  logic [COORD_BITS-2:0] s_second_extent_x,
    input  logic [COORD_BITS-2:0] s_second_extent_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_colliding
);

    localparam int CW = COORD_BITS;

    // stage valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;

    // a stage may take new data when it is empty or its item moves on
    logic rdy1, rdy2, rdy3, rdy4;
    logic load1, load2, load3, load4;

    // stage 1 -> 2
    pair_flags_t   p1_flags;
    logic [CW:0]   p1_dx, p1_dy;
    logic [CW-1:0] p1_rad;
    logic [CW-2:0] p1_w, p1_h;
    logic [CW:0]   p1_wr, p1_hr;

    // stage 2 -> 3
    pair_flags_t   p2_flags;
    logic [CW-1:0] p2_opx, p2_opy, p2_rad;

    // stage 3 -> 4
    pair_flags_t     p3_flags;
    logic [2*CW-1:0] p3_sqx, p3_sqy, p3_sqr;

    assign rdy4 = !v4_reg || m_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    // payload only loads when a real item arrives
    assign load1 = rdy1 && s_valid;
    assign load2 = rdy2 && v1_reg;
    assign load3 = rdy3 && v2_reg;
    assign load4 = rdy4 && v3_reg;

    assign v1_next = rdy1 ? s_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;
    assign v3_next = rdy3 ? v2_reg  : v3_reg;
    assign v4_next = rdy4 ? v3_reg  : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign s_ready = rdy1;
    assign m_valid = v4_reg;

    // stage 1: signed differences, box test, radius and limit sums
    scpt_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .aclk      (aclk),
        .load      (load1),
        .func      (s_func),
        .ax        (s_first_x),
        .ay        (s_first_y),
        .aw        (s_first_extent_x),
        .ah        (s_first_extent_y),
        .bx        (s_second_x),
        .by        (s_second_y),
        .bw        (s_second_extent_x),
        .bh        (s_second_extent_y),
        .flags_reg (p1_flags),
        .dx_reg    (p1_dx),
        .dy_reg    (p1_dy),
        .rad_reg   (p1_rad),
        .w_reg     (p1_w),
        .h_reg     (p1_h),
        .wr_reg    (p1_wr),
        .hr_reg    (p1_hr)
    );

    // stage 2: absolute distances, early reject/accept, squarer operands
    scpt_reduce #(
        .COORD_BITS (COORD_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .load      (load2),
        .flags_in  (p1_flags),
        .dx        (p1_dx),
        .dy        (p1_dy),
        .rad       (p1_rad),
        .w         (p1_w),
        .h         (p1_h),
        .wr        (p1_wr),
        .hr        (p1_hr),
        .flags_reg (p2_flags),
        .opx_reg   (p2_opx),
        .opy_reg   (p2_opy),
        .rad_reg   (p2_rad)
    );

    // stage 3: squares
    scpt_square #(
        .COORD_BITS (COORD_BITS)
    ) u_square (
        .aclk      (aclk),
        .load      (load3),
        .flags_in  (p2_flags),
        .opx       (p2_opx),
        .opy       (p2_opy),
        .rad       (p2_rad),
        .flags_reg (p3_flags),
        .sqx_reg   (p3_sqx),
        .sqy_reg   (p3_sqy),
        .sqr_reg   (p3_sqr)
    );

    // stage 4: distance compare and per-kind select, doubles as output register
    scpt_decide #(
        .COORD_BITS (COORD_BITS)
    ) u_decide (
        .aclk          (aclk),
        .load          (load4),
        .flags_in      (p3_flags),
        .sqx           (p3_sqx),
        .sqy           (p3_sqy),
        .sqr           (p3_sqr),
        .colliding_reg (m_colliding)
    );

endmodule

>>> src/scpt_checker.sv
`include "shape_pair_collision_test_defines.svh"

module scpt_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_colliding
);

    // a stalled result holds
    `SCPT_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_colliding))

    // reset empties the pipe
    `SCPT_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // a free or empty output never blocks the input side
    `SCPT_ASSERT(a_no_false_stall, aclk, aresetn, m_ready || !m_valid |-> s_ready)

    // with the sink always taking, a transfer shows up at the output once it has passed every stage
    `SCPT_ASSERT(a_latency, aclk, aresetn, (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)

endmodule

bind shape_pair_collision_test scpt_checker u_scpt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_colliding (m_colliding)
);

>>> test/shape_pair_collision_test_test.sv
module shape_pair_collision_test_test;
    timeunit 1ns;
    timeprecision 1ps;

    import scpt_pkg::*;

    localparam int CW             = COORD_BITS_DEF;
    localparam int RANDOM_PAIRS   = 800;
    localparam int WATCHDOG_LIMIT = 2000;
    // pipe is four stages deep, leave some margin after the last result
    localparam int DRAIN_CYCLES   = 12;

    // the pair kind with no meaning, always answers no overlap
    localparam func_t FUNC_UNUSED = 2'd3;

    // handy Q15.8 values
    localparam logic [CW-1:0] PMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] PMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] PNEG = 24'hFFFF00;  // -1.0
    localparam logic [CW-1:0] PH   = 24'd128;     // 0.5
    localparam logic [CW-1:0] P1   = 24'd256;     // 1.0
    localparam logic [CW-1:0] P2   = 24'd512;     // 2.0
    localparam logic [CW-2:0] EMAX = '1;
    localparam logic [CW-2:0] EH   = 23'd128;
    localparam logic [CW-2:0] E1   = 23'd256;

    typedef enum int {
        PHASE_FREE,
        PHASE_SEND_IDLE,
        PHASE_RECV_STALL,
        PHASE_BOTH
    } idle_phase_t;

    // one shape pair; known/exp carry a typed-in answer for the obvious rows
    typedef struct packed {
        func_t         kind;
        logic [CW-1:0] first_x;
        logic [CW-1:0] first_y;
        logic [CW-2:0] first_ex;
        logic [CW-2:0] first_ey;
        logic [CW-1:0] second_x;
        logic [CW-1:0] second_y;
        logic [CW-2:0] second_ex;
        logic [CW-2:0] second_ey;
        logic          known;
        logic          exp;
    } pair_item_t;

    // directed pairs: kind, first x y ex ey, second x y ex ey, known, answer
    localparam int DIR_ROWS = 24;
    localparam pair_item_t DIRECTED [0:DIR_ROWS-1] = '{
        // boxes: overlap, shared edge (strict), zero width, zero height
        '{FUNC_RECT_RECT, '0, '0, E1, E1, PH, PH, E1, E1, 1'b1, 1'b1},
        '{FUNC_RECT_RECT, '0, '0, E1, E1, P1, '0, E1, E1, 1'b1, 1'b0},
        '{FUNC_RECT_RECT, '0, '0, '0, E1, '0, '0, E1, E1, 1'b1, 1'b0},
        '{FUNC_RECT_RECT, '0, '0, E1, '0, '0, '0, E1, E1, 1'b1, 1'b0},
        // boxes at the position and size extremes
        '{FUNC_RECT_RECT, PMIN, PMIN, EMAX, EMAX, PMAX, PMAX, EMAX, EMAX, 1'b0, 1'b0},
        '{FUNC_RECT_RECT, PMIN, PMIN, EMAX, EMAX, PNEG, PNEG, 23'd16, 23'd16, 1'b0, 1'b0},
        '{FUNC_RECT_RECT, '1, '1, '1, '1, '1, '1, '1, '1, 1'b0, 1'b0},
        // circles: two zero radii, tiny radii, touching (strict), unused extents set, extremes
        '{FUNC_CIRC_CIRC, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b0},
        '{FUNC_CIRC_CIRC, '0, '0, 23'd1, '0, '0, '0, 23'd1, '0, 1'b1, 1'b1},
        '{FUNC_CIRC_CIRC, '0, '0, E1, '0, P2, '0, E1, '0, 1'b1, 1'b0},
        '{FUNC_CIRC_CIRC, '0, '0, E1, EMAX, 24'd100, '0, E1, EMAX, 1'b1, 1'b1},
        '{FUNC_CIRC_CIRC, PMIN, PMIN, EMAX, '0, PMAX, PMAX, EMAX, '0, 1'b0, 1'b0},
        '{FUNC_CIRC_CIRC, PMAX, PMIN, EMAX, EMAX, PMIN, PMAX, '0, '0, 1'b0, 1'b0},
        // zero radius against a box: inside, on the edge, just outside
        '{FUNC_CIRC_RECT, '0, '0, '0, '0, '0, '0, E1, E1, 1'b1, 1'b1},
        '{FUNC_CIRC_RECT, PH, '0, '0, '0, '0, '0, E1, E1, 1'b1, 1'b1},
        '{FUNC_CIRC_RECT, 24'd129, '0, '0, '0, '0, '0, E1, E1, 1'b1, 1'b0},
        // corner region: clear miss, exact 3-4-5 touch, one step short
        '{FUNC_CIRC_RECT, P1, P1, EH, '0, '0, '0, E1, E1, 1'b0, 1'b0},
        '{FUNC_CIRC_RECT, 24'd224, P1, 23'd160, '0, '0, '0, E1, E1, 1'b0, 1'b0},
        '{FUNC_CIRC_RECT, 24'd224, P1, 23'd159, EMAX, '0, '0, E1, E1, 1'b0, 1'b0},
        // zero-size box, extremes, all ones
        '{FUNC_CIRC_RECT, '0, '0, E1, '0, 24'd100, '0, '0, '0, 1'b0, 1'b0},
        '{FUNC_CIRC_RECT, PMIN, PMIN, EMAX, EMAX, PMAX, PMAX, EMAX, EMAX, 1'b0, 1'b0},
        '{FUNC_CIRC_RECT, '1, '1, '1, '1, '1, '1, '1, '1, 1'b0, 1'b0},
        // unused pair kind never overlaps, even on overlapping data
        '{FUNC_UNUSED, '0, '0, E1, E1, '0, '0, E1, E1, 1'b1, 1'b0},
        '{FUNC_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, 1'b0}
    };

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [1:0]    s_func  = '0;
    logic [CW-1:0] s_first_x = '0;
    logic [CW-1:0] s_first_y = '0;
    logic [CW-2:0] s_first_extent_x = '0;
    logic [CW-2:0] s_first_extent_y = '0;
    logic [CW-1:0] s_second_x = '0;
    logic [CW-1:0] s_second_y = '0;
    logic [CW-2:0] s_second_extent_x = '0;
    logic [CW-2:0] s_second_extent_y = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_colliding;

    pair_item_t pair_list [$];      // every pair to send, in order
    logic       expected_hits [$];  // overlap answers still owed by the block
    int         n_loaded   = 0;
    int         n_accepted = 0;
    int         fail_count = 0;

    shape_pair_collision_test #(.COORD_BITS(CW)) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_first_x         (s_first_x),
        .s_first_y         (s_first_y),
        .s_first_extent_x  (s_first_extent_x),
        .s_first_extent_y  (s_first_extent_y),
        .s_second_x        (s_second_x),
        .s_second_y        (s_second_y),
        .s_second_extent_x (s_second_extent_x),
        .s_second_extent_y (s_second_extent_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_colliding       (m_colliding)
    );

    always #1 aclk = ~aclk;

    // overlap answer for one pair, exact integer math on the raw Q15.8 values;
    // 64 bits hold every square here since distances stay below 2^25
    function automatic logic predict_overlap(pair_item_t p);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint dx, dy, dx2, dy2, r2, rsum;
        logic   hit;
        ax = longint'($signed(p.first_x));
        ay = longint'($signed(p.first_y));
        aw = longint'(p.first_ex);
        ah = longint'(p.first_ey);
        bx = longint'($signed(p.second_x));
        by = longint'($signed(p.second_y));
        bw = longint'(p.second_ex);
        bh = longint'(p.second_ey);
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        hit = 1'b0;
        case (p.kind)
            FUNC_RECT_RECT: begin
                // positions are minimum corners, strict on every side
                hit = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
            end
            FUNC_CIRC_CIRC: begin
                rsum = aw + bw;
                hit  = (dx * dx + dy * dy) < (rsum * rsum);
            end
            FUNC_CIRC_RECT: begin
                // box position is its centre; everything doubled so halves stay whole
                dx2 = 2 * dx;
                dy2 = 2 * dy;
                r2  = 2 * aw;
                if (dx2 > bw + r2 || dy2 > bh + r2) begin
                    hit = 1'b0;
                end else if (dx2 <= bw || dy2 <= bh) begin
                    hit = 1'b1;
                end else begin
                    hit = ((dx2 - bw) * (dx2 - bw) + (dy2 - bh) * (dy2 - bh)) <= r2 * r2;
                end
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [CW-1:0] rand_pos();
        logic [31:0] r;
        r = $urandom;
        return r[CW-1:0];
    endfunction

    function automatic logic [CW-2:0] rand_ext(int nbits);
        logic [31:0] r;
        r = $urandom & ((32'd1 << nbits) - 32'd1);
        return r[CW-2:0];
    endfunction

    // a position within two times 2^scale of base, either side
    function automatic logic [CW-1:0] near_pos(logic [CW-1:0] base, int scale);
        longint off;
        longint sum;
        off = longint'($urandom_range(0, 4 << scale)) - longint'(2 << scale);
        sum = longint'($signed(base)) + off;
        return sum[CW-1:0];
    endfunction

    // one process drives both channels and checks results, all on the
    // rising edge; it reads pre-edge values, so there is no race with the rtl
    always @(posedge aclk) begin : pair_traffic
        logic        in_xfer;
        logic        out_xfer;
        logic        want;
        idle_phase_t phase;
        int          send_idle_pct;
        int          stall_pct;
        int          quiet_cycles;
        pair_item_t  cur_pair;
        logic        cur_hit;
        if (!aresetn) begin
            s_valid      <= 1'b0;
            m_ready      <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_xfer  = s_valid && s_ready;
            out_xfer = m_valid && m_ready;

            // the pair on the bus went in, its answer is now owed
            if (in_xfer) begin
                expected_hits.push_back(cur_hit);
                n_accepted++;
            end

            // results come back strictly in order
            if (out_xfer) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing owed (colliding=%b)",
                                              m_colliding));
                end else begin
                    want = expected_hits.pop_front();
                    if (m_colliding !== want) begin
                        report_mismatch($sformatf("colliding=%b, wanted %b", m_colliding, want));
                    end
                end
            end

            // idling phases advance with the stimulus: none, sender, receiver, both
            phase = idle_phase_t'((n_loaded * 4) / pair_list.size());
            if (n_loaded * 4 >= 3 * pair_list.size()) begin
                phase = PHASE_BOTH;
            end
            case (phase)
                PHASE_FREE:       begin send_idle_pct = 0;  stall_pct = 0;  end
                PHASE_SEND_IDLE:  begin send_idle_pct = 80; stall_pct = 0;  end
                PHASE_RECV_STALL: begin send_idle_pct = 0;  stall_pct = 80; end
                default:          begin send_idle_pct = 19; stall_pct = 19; end
            endcase

            m_ready <= ($urandom_range(0, 99) >= stall_pct);

            // valid stays up with a steady payload until the transfer happens
            if (!s_valid || in_xfer) begin
                if (n_loaded < pair_list.size() && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_pair = pair_list[n_loaded];
                    cur_hit  = cur_pair.known ? cur_pair.exp : predict_overlap(cur_pair);
                    n_loaded++;
                    s_valid           <= 1'b1;
                    s_func            <= cur_pair.kind;
                    s_first_x         <= cur_pair.first_x;
                    s_first_y         <= cur_pair.first_y;
                    s_first_extent_x  <= cur_pair.first_ex;
                    s_first_extent_y  <= cur_pair.first_ey;
                    s_second_x        <= cur_pair.second_x;
                    s_second_y        <= cur_pair.second_y;
                    s_second_extent_x <= cur_pair.second_ex;
                    s_second_extent_y <= cur_pair.second_ey;
                end else begin
                    s_valid <= 1'b0;
                end
            end

            // watchdog: no transfer on either side for too long
            if (in_xfer || out_xfer) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results owed",
                         WATCHDOG_LIMIT, expected_hits.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus_and_end
        pair_item_t  p;
        int          mode;
        int          scale;
        logic [31:0] r;

        // directed table first
        for (int i = 0; i < DIR_ROWS; i++) begin
            pair_list.push_back(DIRECTED[i]);
        end

        // random pairs: mostly shapes placed near each other at a random size
        // scale so hits and misses both show up, plus fully random bits and extremes
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            p     = '0;
            mode  = $urandom_range(0, 9);
            p.kind = ($urandom_range(0, 19) == 0) ? FUNC_UNUSED
                                                  : func_t'($urandom_range(0, 2));
            if (mode < 7) begin
                scale       = $urandom_range(2, 20);
                p.first_x   = rand_pos();
                p.first_y   = rand_pos();
                p.first_ex  = rand_ext(scale);
                p.first_ey  = rand_ext(scale);
                p.second_x  = near_pos(p.first_x, scale);
                p.second_y  = near_pos(p.first_y, scale);
                p.second_ex = rand_ext(scale);
                p.second_ey = rand_ext(scale);
            end else if (mode < 9) begin
                p.first_x   = rand_pos();
                p.first_y   = rand_pos();
                p.first_ex  = rand_ext(CW - 1);
                p.first_ey  = rand_ext(CW - 1);
                p.second_x  = rand_pos();
                p.second_y  = rand_pos();
                p.second_ex = rand_ext(CW - 1);
                p.second_ey = rand_ext(CW - 1);
            end else begin
                // corners of the number range and full or empty sizes
                r           = $urandom;
                p.first_x   = r[0] ? PMIN : PMAX;
                p.first_y   = r[1] ? PMIN : PMAX;
                p.first_ex  = r[2] ? EMAX : '0;
                p.first_ey  = r[3] ? EMAX : '0;
                p.second_x  = r[4] ? PMIN : PMAX;
                p.second_y  = r[5] ? PMIN : PMAX;
                p.second_ex = r[6] ? EMAX : '0;
                p.second_ey = r[7] ? EMAX : '0;
            end
            pair_list.push_back(p);
        end

        // single reset at the start
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // everything sent and every answer back
        while (!(n_accepted == pair_list.size() && expected_hits.size() == 0)) begin
            @(posedge aclk);
        end
        // stray late results would still be flagged here
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
